// ===== src/dtlf_pkg.sv =====
// Package for the lowest-free descriptor table.
// Transfer structs, command and status codes, table constants.
// No dependencies.
`default_nettype none

package dtlf_pkg;

    localparam int TABLE_SLOTS_DEF = 64;
    localparam int FIRST_FREE      = 3;    // serial slots set up by init

    localparam logic [1:0] CMD_INIT  = 2'd0;
    localparam logic [1:0] CMD_ALLOC = 2'd1;
    localparam logic [1:0] CMD_CLOSE = 2'd2;
    localparam logic [1:0] CMD_GET   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam logic [3:0] KIND_EMPTY  = 4'd0;
    localparam logic [3:0] KIND_SERIAL = 4'd1;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [11:0] slot_index;
        logic [3:0]         entry_kind;
        logic [63:0]        entry_handle;
        logic [31:0]        entry_mode_bits;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  given_index;
        logic [3:0]  read_kind;
        logic [63:0] read_handle;
        logic [31:0] read_mode_bits;
        logic [6:0]  high_mark;
    } t_out;

    typedef struct packed {
        logic [3:0]  kind;
        logic [63:0] handle;
        logic [31:0] mode;
    } t_entry;

    typedef struct packed {
        logic init;     // back to the serial layout
        logic wr;       // write one occupancy bit
        logic wr_val;
    } t_occ_cmd;

    // flags of the serial slots after init: read-only, then write-only
    function automatic logic [31:0] init_mode(input logic [1:0] slot);
        return (slot == 2'd0) ? 32'd0 : 32'd1;
    endfunction

endpackage

`default_nettype wire

// ===== src/dtlf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dtlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== src/dtlf_occ.sv =====
// Occupancy bits and lowest-free search (per-byte stage registered,
// then group select). Depends on dtlf_pkg.
`default_nettype none

module dtlf_occ #(
    parameter int TABLE_SLOTS = dtlf_pkg::TABLE_SLOTS_DEF,
    parameter int SW          = $clog2(TABLE_SLOTS)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire dtlf_pkg::t_occ_cmd i_cmd,
    input  wire logic [SW-1:0]      i_wr_slot,
    input  wire logic [SW-1:0]      i_rd_slot,
    input  wire logic               i_load,
    output logic                    o_rd_occ,
    output logic                    o_found,
    output logic [SW-1:0]           o_slot
);

    localparam int G    = (TABLE_SLOTS + 7) / 8;
    localparam int PADW = G * 8;
    localparam int GW   = (G > 1) ? $clog2(G) : 1;

    logic [TABLE_SLOTS-1:0] r_occ;
    logic [PADW-1:0]        w_pad;
    logic [G-1:0]           n_gfree, r_gfree;
    logic [2:0]             n_glow [G];
    logic [2:0]             r_glow [G];
    logic [G-1:0]           w_gsel;
    logic [GW-1:0]          w_grp;

    for (genvar b = 0; b < PADW; b++) begin : g_pad
        if (b < TABLE_SLOTS) begin : g_real
            assign w_pad[b] = r_occ[b];
        end else begin : g_fill
            assign w_pad[b] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.init) begin
            for (int b = 0; b < TABLE_SLOTS; b++) begin
                r_occ[b] <= (b < dtlf_pkg::FIRST_FREE);
            end
        end else if (i_cmd.wr) begin
            r_occ[i_wr_slot] <= i_cmd.wr_val;
        end
    end

    // per byte: any free bit and the lowest one
    always_comb begin
        logic [7:0] free;
        logic [7:0] sel;
        for (int g = 0; g < G; g++) begin
            free       = ~w_pad[g*8 +: 8];
            sel        = free & (~free + 8'd1);
            n_gfree[g] = |free;
            n_glow[g]  = 3'd0;
            for (int k = 0; k < 8; k++) begin
                if (sel[k]) begin
                    n_glow[g] = n_glow[g] | 3'(k);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_gfree <= n_gfree;
            r_glow  <= n_glow;
        end
    end

    assign w_gsel = r_gfree & (~r_gfree + G'(1));

    always_comb begin
        w_grp = '0;
        for (int g = 0; g < G; g++) begin
            if (w_gsel[g]) begin
                w_grp = w_grp | GW'(g);
            end
        end
    end

    assign o_found  = |r_gfree;
    assign o_slot   = SW'({w_grp, r_glow[w_grp]});
    assign o_rd_occ = r_occ[i_rd_slot];

endmodule

`default_nettype wire

// ===== src/descriptor_table_lowest_free.sv =====
// Lowest-free descriptor table: top level with command sequencer,
// entry RAM and result register. Depends on dtlf_pkg, dtlf_occ, dtlf_ram.
//
// Use:
//   Input channel (i_in_valid / o_in_stall / i_in) carries one command per
//   transfer: init, allocate lowest free slot, close slot, get slot.
//   Output channel (o_out_valid / i_out_stall / o_out) returns exactly one
//   result per command, in order.
//   The sequencer steps through accept, search and execute for each command
//   and takes no new command until execute is done; the byte-level free
//   search is registered before the group select and the entry RAM read is
//   registered in the search state, so both land in the execute state.
//   A held result does not block acceptance of the next command; that
//   command waits in execute until the result register is taken.
//   Reset (synchronous, active low) gives the init layout: slots 0 to 2
//   serial with flags 0, 1, 1, the rest empty, high mark 3. Entry RAM needs
//   no clearing: empty slots are never read back.
`default_nettype none

module descriptor_table_lowest_free #(
    parameter int TABLE_SLOTS = dtlf_pkg::TABLE_SLOTS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire dtlf_pkg::t_in  i_in,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output dtlf_pkg::t_out      o_out
);

    localparam int SW = $clog2(TABLE_SLOTS);
    localparam int HW = $clog2(TABLE_SLOTS + 1);
    localparam int NI = dtlf_pkg::FIRST_FREE;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SRCH = 3'b010,
        S_EXEC = 3'b100
    } t_state;

    t_state                  r_state, n_state;
    dtlf_pkg::t_in           r_in;
    dtlf_pkg::t_out          r_out, n_out;
    logic                    r_out_valid;
    logic [HW-1:0]           r_high, n_high;
    logic [NI-1:0]           r_init, n_init;

    logic                    w_in_xfer;
    logic                    w_out_free;
    logic                    w_go;
    logic                    w_idx_ok;
    logic [SW-1:0]           w_rd_slot;
    logic [SW-1:0]           w_wr_slot;
    logic                    w_rd_occ;
    logic                    w_found;
    logic [SW-1:0]           w_found_slot;
    logic                    w_rd_init;
    logic                    w_ram_we;
    dtlf_pkg::t_entry        w_wr_entry;
    dtlf_pkg::t_entry        w_rd_entry;
    dtlf_pkg::t_occ_cmd      w_occ_eff, w_occ_cmd;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_go       = (r_state == S_EXEC) && w_out_free;

    assign w_rd_slot  = r_in.slot_index[SW-1:0];
    assign w_idx_ok   = !r_in.slot_index[11]
                        && ({21'd0, r_in.slot_index[10:0]} < 32'(TABLE_SLOTS));
    assign w_rd_init  = (w_rd_slot < SW'(NI)) && r_init[w_rd_slot[1:0]];

    assign w_wr_entry = '{kind:   r_in.entry_kind,
                          handle: r_in.entry_handle,
                          mode:   r_in.entry_mode_bits};

    dtlf_occ #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .SW          (SW)
    ) u_occ (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_occ_cmd),
        .i_wr_slot (w_wr_slot),
        .i_rd_slot (w_rd_slot),
        .i_load    (r_state == S_SRCH),
        .o_rd_occ  (w_rd_occ),
        .o_found   (w_found),
        .o_slot    (w_found_slot)
    );

    dtlf_ram #(
        .WIDTH ($bits(dtlf_pkg::t_entry)),
        .DEPTH (TABLE_SLOTS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_we && w_go),
        .i_wr_addr (w_found_slot),
        .i_wr_data (w_wr_entry),
        .i_rd_en   (r_state == S_SRCH),
        .i_rd_addr (w_rd_slot),
        .o_rd_data (w_rd_entry)
    );

    always_comb begin
        n_out       = '0;
        n_out.status = dtlf_pkg::ST_OK;
        n_high      = r_high;
        n_init      = r_init;
        w_occ_eff   = '0;
        w_wr_slot   = w_rd_slot;
        w_ram_we    = 1'b0;
        unique case (r_in.cmd)
            dtlf_pkg::CMD_INIT: begin
                w_occ_eff.init = 1'b1;
                n_high         = HW'(NI);
                n_init         = '1;
            end
            dtlf_pkg::CMD_ALLOC: begin
                if (w_found) begin
                    w_ram_we          = 1'b1;
                    w_occ_eff.wr      = 1'b1;
                    w_occ_eff.wr_val  = (r_in.entry_kind != dtlf_pkg::KIND_EMPTY);
                    w_wr_slot         = w_found_slot;
                    n_out.given_index = 6'(w_found_slot);
                    if (w_found_slot < SW'(NI)) begin
                        n_init[w_found_slot[1:0]] = 1'b0;
                    end
                    if (HW'(w_found_slot) >= r_high) begin
                        n_high = HW'(w_found_slot) + HW'(1);
                    end
                end else begin
                    n_out.status = dtlf_pkg::ST_FULL;
                end
            end
            dtlf_pkg::CMD_CLOSE, dtlf_pkg::CMD_GET: begin
                if (!w_idx_ok) begin
                    n_out.status = dtlf_pkg::ST_RANGE;
                end else if (!w_rd_occ) begin
                    n_out.status = dtlf_pkg::ST_EMPTY;
                end else if (r_in.cmd == dtlf_pkg::CMD_CLOSE) begin
                    w_occ_eff.wr     = 1'b1;
                    w_occ_eff.wr_val = 1'b0;
                end else if (w_rd_init) begin
                    n_out.read_kind      = dtlf_pkg::KIND_SERIAL;
                    n_out.read_mode_bits = dtlf_pkg::init_mode(w_rd_slot[1:0]);
                end else begin
                    n_out.read_kind      = w_rd_entry.kind;
                    n_out.read_handle    = w_rd_entry.handle;
                    n_out.read_mode_bits = w_rd_entry.mode;
                end
            end
        endcase
        n_out.high_mark = 7'(n_high);
    end

    assign w_occ_cmd = w_go ? w_occ_eff : '0;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_in_xfer) n_state = S_SRCH;
            S_SRCH: n_state = S_EXEC;
            S_EXEC: if (w_out_free) n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_high      <= HW'(NI);
            r_init      <= '1;
        end else begin
            r_state <= n_state;
            if (w_go) begin
                r_out_valid <= 1'b1;
                r_high      <= n_high;
                r_init      <= n_init;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in <= i_in;
        end
        if (w_go) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ===== src/dtlf_chk.sv =====
// Port-level checker for descriptor_table_lowest_free, bound to the top.
// Depends on dtlf_pkg.
`default_nettype none

module dtlf_chk (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           o_in_stall,
    input wire dtlf_pkg::t_in  i_in,
    input wire logic           o_out_valid,
    input wire logic           i_out_stall,
    input wire dtlf_pkg::t_out o_out
);

    // one command in flight at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transfer accepted while busy");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("channels not quiet after reset");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status != dtlf_pkg::ST_OK |->
            o_out.given_index == 6'd0 && o_out.read_kind == 4'd0
            && o_out.read_handle == 64'd0 && o_out.read_mode_bits == 32'd0)
        else $error("failed command carries data");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

endmodule

bind descriptor_table_lowest_free dtlf_chk u_dtlf_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

`default_nettype wire
